// ===== sv/okt_pkg.sv =====
// Package for the ordered keyed table: opcodes, status codes, result selects
// and the command/status bundles between the controller and the datapath.
// No dependencies.
package okt_pkg;

	// Request opcodes
	localparam logic [3:0] OP_INSERT   = 4'd0;
	localparam logic [3:0] OP_SEARCH   = 4'd1;
	localparam logic [3:0] OP_REMOVE   = 4'd2;
	localparam logic [3:0] OP_LIST_FWD = 4'd3;
	localparam logic [3:0] OP_LIST_REV = 4'd4;
	localparam logic [3:0] OP_EMPTY    = 4'd5;
	localparam logic [3:0] OP_MAX      = 4'd6;
	localparam logic [3:0] OP_MIN      = 4'd7;
	localparam logic [3:0] OP_CLEAR    = 4'd8;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	// Result payload sources
	localparam logic [2:0] RES_ZERO = 3'd0;
	localparam logic [2:0] RES_REQ  = 3'd1;
	localparam logic [2:0] RES_MISS = 3'd2;
	localparam logic [2:0] RES_BEST = 3'd3;
	localparam logic [2:0] RES_RAM  = 3'd4;

	// Entry storage word: value in the upper half, code in the lower half
	localparam int ENTRY_W = 32;

	typedef struct packed {
		logic       req_load;     // capture the request fields
		logic       write_ins;    // write the request at the tail
		logic       cnt_inc;
		logic       cnt_dec;
		logic       cnt_clr;
		logic       idx_from_pos; // restart the pointer after the removed entry
		logic       rd_run;       // stream reads while the pointer is below the count
		logic       chk_en;       // compare returning read data
		logic       shift_en;     // write returning read data one slot down
		logic       list_rd;      // single read for a list step
		logic       out_load;
		logic [2:0] res_sel;
		logic [1:0] res_status;
		logic       res_last;
	} okt_cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       cnt_zero;
		logic       full;
		logic       run_done;  // all reads issued and returned
		logic       hit;
		logic       list_last;
		logic       out_free;
	} okt_sts_t;

endpackage

// ===== sv/okt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module okt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/okt_ctrl.sv =====
// Controller state machine for the ordered keyed table.
// Depends on okt_pkg; drives okt_dp through okt_cmd_t and reads okt_sts_t.
module okt_ctrl
	import okt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  okt_sts_t sts,
	output okt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_SHIFT    = 3'd3;
	localparam logic [2:0] S_LIST_RD  = 3'd4;
	localparam logic [2:0] S_LIST_OUT = 3'd5;
	localparam logic [2:0] S_EMIT     = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] em_sel_q, em_sel_d;
	logic [1:0] em_stat_q, em_stat_d;
	logic       em_load;
	logic       scan_end;

	assign in_ready = (state_q == S_IDLE);
	assign scan_end = sts.run_done || sts.hit;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		em_load   = 1'b0;
		em_sel_d  = RES_ZERO;
		em_stat_d = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				em_load = 1'b1;
				case (sts.op)
					OP_INSERT: begin
						em_sel_d = RES_REQ;
						if (sts.full) begin
							em_stat_d = STAT_FULL;
						end else begin
							cmd.write_ins = 1'b1;
							cmd.cnt_inc   = 1'b1;
						end
					end
					OP_SEARCH, OP_REMOVE: begin
						if (sts.cnt_zero) begin
							em_sel_d  = RES_MISS;
							em_stat_d = STAT_NOTFOUND;
						end else begin
							em_load = 1'b0;
							state_d = S_SCAN;
						end
					end
					OP_MAX, OP_MIN: begin
						if (sts.cnt_zero) begin
							em_stat_d = STAT_EMPTY;
						end else begin
							em_load = 1'b0;
							state_d = S_SCAN;
						end
					end
					OP_LIST_FWD, OP_LIST_REV: begin
						if (sts.cnt_zero) begin
							em_stat_d = STAT_EMPTY;
						end else begin
							em_load = 1'b0;
							state_d = S_LIST_RD;
						end
					end
					OP_EMPTY: begin
						em_stat_d = sts.cnt_zero ? STAT_EMPTY : STAT_OK;
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					default: begin
						// drop unknown opcodes without a result
						em_load = 1'b0;
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.chk_en = 1'b1;
				cmd.rd_run = !scan_end;
				if (scan_end) begin
					if ((sts.op == OP_MAX) || (sts.op == OP_MIN)) begin
						em_load  = 1'b1;
						em_sel_d = RES_BEST;
						state_d  = S_EMIT;
					end else if (!sts.hit) begin
						em_load   = 1'b1;
						em_sel_d  = RES_MISS;
						em_stat_d = STAT_NOTFOUND;
						state_d   = S_EMIT;
					end else if (sts.op == OP_REMOVE) begin
						cmd.idx_from_pos = 1'b1;
						state_d          = S_SHIFT;
					end else begin
						em_load  = 1'b1;
						em_sel_d = RES_BEST;
						state_d  = S_EMIT;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift_en = 1'b1;
				cmd.rd_run   = !sts.run_done;
				if (sts.run_done) begin
					cmd.cnt_dec = 1'b1;
					em_load     = 1'b1;
					em_sel_d    = RES_BEST;
					state_d     = S_EMIT;
				end
			end
			S_LIST_RD: begin
				cmd.list_rd = 1'b1;
				state_d     = S_LIST_OUT;
			end
			S_LIST_OUT: begin
				cmd.res_sel    = RES_RAM;
				cmd.res_status = STAT_OK;
				cmd.res_last   = sts.list_last;
				cmd.out_load   = sts.out_free;
				if (sts.out_free) begin
					state_d = sts.list_last ? S_IDLE : S_LIST_RD;
				end
			end
			S_EMIT: begin
				cmd.res_sel    = em_sel_q;
				cmd.res_status = em_stat_q;
				cmd.res_last   = 1'b1;
				cmd.out_load   = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the pending single result
	always_ff @(posedge clk) begin
		if (em_load) begin
			em_sel_q  <= em_sel_d;
			em_stat_q <= em_stat_d;
		end
	end

endmodule

// ===== sv/okt_dp.sv =====
// Datapath for the ordered keyed table: request registers, entry RAM, count,
// read pointer, compare logic and output register. Depends on okt_pkg, okt_ram.
module okt_dp
	import okt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         in_opcode,
	input  logic [15:0]        in_key,
	input  logic signed [15:0] in_val,
	input  okt_cmd_t           cmd,
	output okt_sts_t           sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         out_status,
	output logic [15:0]        out_key,
	output logic signed [15:0] out_val,
	output logic [4:0]         out_total,
	output logic               out_last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [3:0]         op_q;
	logic [15:0]        key_q;
	logic signed [15:0] val_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      rev_idx;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               hit_q;
	logic [AW-1:0]      pos_q;
	logic [15:0]        best_key_q;
	logic signed [15:0] best_val_q;
	logic               out_valid_q;

	logic               rd_go;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [15:0]        rd_key;
	logic signed [15:0] rd_val;
	logic               is_find;
	logic               take_hit;
	logic               take_ext;
	logic               better;
	logic [15:0]        res_key;
	logic signed [15:0] res_val;

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q  <= in_opcode;
			key_q <= in_key;
			val_q <= in_val;
		end
	end

	// Read and write port steering
	assign rd_go     = cmd.rd_run && (idx_q < cnt_q);
	assign rev_idx   = cnt_q - CW'(1) - idx_q;
	assign ram_re    = rd_go || cmd.list_rd;
	assign ram_raddr = (cmd.list_rd && (op_q == OP_LIST_REV)) ? rev_idx[AW-1:0] : idx_q[AW-1:0];
	assign ram_we    = cmd.write_ins || (cmd.shift_en && rd_vld_s1);
	assign ram_waddr = cmd.write_ins ? AW'(cnt_q) : AW'(rd_idx_s1 - AW'(1));
	assign ram_wdata = cmd.write_ins ? {val_q, key_q} : ram_rdata;
	assign rd_key    = ram_rdata[15:0];
	assign rd_val    = $signed(ram_rdata[31:16]);

	okt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.req_load) begin
				idx_q <= '0;
			end else if (cmd.idx_from_pos) begin
				idx_q <= CW'(pos_q) + CW'(1);
			end else if (ram_re) begin
				idx_q <= idx_q + CW'(1);
			end
			rd_vld_s1 <= rd_go;
		end
	end

	// Track the address of the data in flight
	always_ff @(posedge clk) begin
		if (rd_go) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
	end

	// Compare returning entries
	assign is_find  = (op_q == OP_SEARCH) || (op_q == OP_REMOVE);
	assign better   = (op_q == OP_MAX) ? (rd_val > best_val_q) : (rd_val < best_val_q);
	assign take_hit = cmd.chk_en && rd_vld_s1 && is_find && !hit_q && (rd_key == key_q);
	assign take_ext = cmd.chk_en && rd_vld_s1 && !is_find && ((rd_idx_s1 == '0) || better);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.req_load) begin
			hit_q <= 1'b0;
		end else if (take_hit) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit || take_ext) begin
			best_key_q <= rd_key;
			best_val_q <= rd_val;
		end
		if (take_hit) begin
			pos_q <= rd_idx_s1;
		end
	end

	// Result payload select
	always_comb begin
		case (cmd.res_sel)
			RES_REQ: begin
				res_key = key_q;
				res_val = val_q;
			end
			RES_MISS: begin
				res_key = key_q;
				res_val = '0;
			end
			RES_BEST: begin
				res_key = best_key_q;
				res_val = best_val_q;
			end
			RES_RAM: begin
				res_key = rd_key;
				res_val = rd_val;
			end
			default: begin
				res_key = '0;
				res_val = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= cmd.res_status;
			out_key    <= res_key;
			out_val    <= res_val;
			out_total  <= 5'(cnt_q);
			out_last   <= cmd.res_last;
		end
	end

	assign out_valid = out_valid_q;

	// Status back to the controller
	assign sts.op        = op_q;
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.full      = (cnt_q >= CW'(CAPACITY));
	assign sts.run_done  = (idx_q >= cnt_q) && !rd_vld_s1;
	assign sts.hit       = hit_q;
	assign sts.list_last = (idx_q == cnt_q);
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ===== sv/ordered_keyed_table_with_extremes.sv =====
// Each request is decoded first. Insert, empty, clear and misses on an empty table then load
// their result; unknown opcodes are dropped with no result. Search and max/min first scan the
// entries, remove scans and then shifts the later entries down one slot, and a list reads each
// entry and loads it as a result in turn. The entry RAM read port streams one entry a cycle in a scan or shift.
// One request is worked at a time; the next is taken the cycle after its last result is loaded.
// Reset clears the count and control state at once; entry storage is not cleared.
module ordered_keyed_table_with_extremes
	import okt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // key_code[15:0], value_in[31:16]
	input  logic [3:0]  s_axis_tuser,  // opcode[3:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // key_out[15:0], value_out[31:16], entry_total[36:32]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	output logic        m_axis_tlast   // last_of_run
);

	okt_cmd_t           cmd;
	okt_sts_t           sts;
	logic [15:0]        key_out;
	logic signed [15:0] value_out;
	logic [4:0]         entry_total;

	okt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	okt_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_opcode  (s_axis_tuser),
		.in_key     (s_axis_tdata[15:0]),
		.in_val     ($signed(s_axis_tdata[31:16])),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (m_axis_tuser),
		.out_key    (key_out),
		.out_val    (value_out),
		.out_total  (entry_total),
		.out_last   (m_axis_tlast)
	);

	// Pack the result
	assign m_axis_tdata = {3'b000, entry_total, value_out, key_out};

endmodule

// ===== sv/okt_chk.sv =====
// Port-level checker for the ordered keyed table, bound to the top level.
// Depends on okt_pkg.
module okt_chk
	import okt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

	// One request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while another is in work");

	// Full only with the table at capacity
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STAT_FULL)) |->
		((m_axis_tdata[36:32] == 5'(CAPACITY)) && m_axis_tlast))
		else $error("full status with wrong entry total");

	// Empty status reports nothing held
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STAT_EMPTY)) |->
		((m_axis_tdata[39:0] == 40'd0) && m_axis_tlast))
		else $error("empty status with nonzero payload");

	// Entry total stays within capacity
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((CAPACITY > 31) || (m_axis_tdata[36:32] <= 5'(CAPACITY))))
		else $error("entry total above capacity");

endmodule

bind ordered_keyed_table_with_extremes okt_chk #(.CAPACITY(CAPACITY)) u_okt_chk (.*);
